@@ hdl/esc_pkg.sv @@
package esc_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_TEMP       = 3'd0,
		CFG_PRESS_LOW  = 3'd1,
		CFG_PRESS_HIGH = 3'd2,
		CFG_P9_HUM     = 3'd3,
		CFG_HUM        = 3'd4
	} cfg_idx_t;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 64;

	// pipeline geometry
	localparam int unsigned DivBits   = 32;
	localparam int unsigned TempStage = 4;
	localparam int unsigned HumStage  = 12;
	localparam int unsigned FrontEnd  = 10;
	localparam int unsigned Depth     = FrontEnd + DivBits + 3;

	localparam logic [31:0] K_64000    = 32'd64000;
	localparam logic [31:0] K_1048576  = 32'd1048576;
	localparam logic [31:0] K_3125     = 32'd3125;
	localparam logic [31:0] K_76800    = 32'd76800;
	localparam logic [31:0] K_16384    = 32'd16384;
	localparam logic [31:0] K_32768    = 32'd32768;
	localparam logic [31:0] K_2097152  = 32'd2097152;
	localparam logic [31:0] K_8192     = 32'd8192;
	localparam logic [31:0] K_HUM_MAX  = 32'd419430400;
	localparam logic [31:0] K_ROUND128 = 32'd128;

	// calibration words, each widened to 32 bits
	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
	} coef_t;

	// arithmetic right shift on a 32-bit two's complement word
	function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
		return 32'($signed(x) >>> n);
	endfunction

endpackage

@@ hdl/env_sensor_compensation.sv @@
// environmental sensor compensation, integer formulas
//
// input channel: in_valid / in_stall with raw_pressure, raw_temperature and
// raw_humidity; one beat is one sensor burst
// output channel: out_valid / out_stall with temperature_centi, pressure_pa,
// pressure_valid and humidity_q22_10; one result beat for every input beat
// config: cfg_we / cfg_idx / cfg_wdata write one calibration register per
// cycle; the user must write only while no beat is in flight (unchecked)
//
// throughput is one beat per clock while out_stall does not hold the
// pipeline; the pipeline has 45 register stages, set by the 32-stage
// bit-per-stage pressure divider plus the temperature, divisor setup and
// pressure trim stages around it
// the whole pipeline advances together: when a result sits at the output
// and out_stall is high, every stage holds and in_stall goes high, so no
// beat is lost or repeated; bubbles move on whenever the output is free
// reset clears all calibration registers and the valid bits of every stage;
// data registers are not reset
module env_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [esc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [esc_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [19:0]                   raw_pressure,
	input  logic [19:0]                   raw_temperature,
	input  logic [15:0]                   raw_humidity,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   temperature_centi,
	output logic [31:0]                   pressure_pa,
	output logic                          pressure_valid,
	output logic [16:0]                   humidity_q22_10
);

	localparam int unsigned D      = esc_pkg::Depth;
	localparam int unsigned TempDl = D - esc_pkg::TempStage;
	localparam int unsigned HumDl  = D - esc_pkg::HumStage;

	esc_pkg::coef_t coef;
	logic           en;

	// one valid bit per stage, last one is the output
	logic [D-1:0]   vld_q;

	logic [31:0] temp_s4, hv_s4, dvd_s10, dvs_s10, quo;
	logic [15:0] adch_s4;
	logic        mode_s10, nz_s10, mode_div, nz_div;
	logic [16:0] hum_s12;

	// temperature and humidity are ready early and wait here for pressure
	logic [31:0] temp_dl_q [TempDl];
	logic [16:0] hum_dl_q  [HumDl];

	// advance unless a finished beat is held by the receiver
	assign en       = !vld_q[D-1] || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[D-2:0], in_valid};
	end

	esc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	esc_front u_front (
		.clk             (clk),
		.en              (en),
		.coef            (coef),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.temp_s4         (temp_s4),
		.hv_s4           (hv_s4),
		.adch_s4         (adch_s4),
		.dvd_s10         (dvd_s10),
		.dvs_s10         (dvs_s10),
		.mode_s10        (mode_s10),
		.nz_s10          (nz_s10)
	);

	esc_hum u_hum (
		.clk     (clk),
		.en      (en),
		.coef    (coef),
		.hv_s4   (hv_s4),
		.adch_s4 (adch_s4),
		.hum_s12 (hum_s12)
	);

	esc_div u_div (
		.clk      (clk),
		.en       (en),
		.dvd      (dvd_s10),
		.dvs      (dvs_s10),
		.mode     (mode_s10),
		.nz       (nz_s10),
		.quo      (quo),
		.mode_out (mode_div),
		.nz_out   (nz_div)
	);

	esc_ptrim u_ptrim (
		.clk        (clk),
		.en         (en),
		.coef       (coef),
		.quo        (quo),
		.mode       (mode_div),
		.nz         (nz_div),
		.pres_out   (pressure_pa),
		.pvalid_out (pressure_valid)
	);

	// delay lines, shifted together with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			temp_dl_q[0] <= temp_s4;
			for (int i = 1; i < TempDl; i++)
				temp_dl_q[i] <= temp_dl_q[i-1];
			hum_dl_q[0] <= hum_s12;
			for (int i = 1; i < HumDl; i++)
				hum_dl_q[i] <= hum_dl_q[i-1];
		end
	end

	assign out_valid         = vld_q[D-1];
	assign temperature_centi = temp_dl_q[TempDl-1];
	assign humidity_q22_10   = hum_dl_q[HumDl-1];

endmodule

@@ hdl/esc_cfg.sv @@
module esc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [esc_pkg::CfgIdxW-1:0]       cfg_idx,
	input  logic [esc_pkg::CfgDataW-1:0]      cfg_wdata,
	output esc_pkg::coef_t                    coef
);

	logic [47:0] temp_q;
	logic [63:0] plow_q;
	logic [63:0] phigh_q;
	logic [47:0] p9hum_q;
	logic [31:0] hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			p9hum_q <= '0;
			hum_q   <= '0;
		end else if (cfg_we) begin
			case (esc_pkg::cfg_idx_t'(cfg_idx))
				esc_pkg::CFG_TEMP:       temp_q  <= cfg_wdata[47:0];
				esc_pkg::CFG_PRESS_LOW:  plow_q  <= cfg_wdata;
				esc_pkg::CFG_PRESS_HIGH: phigh_q <= cfg_wdata;
				esc_pkg::CFG_P9_HUM:     p9hum_q <= cfg_wdata[47:0];
				esc_pkg::CFG_HUM:        hum_q   <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1 = {16'd0, temp_q[15:0]};
		coef.t2 = {{16{temp_q[31]}}, temp_q[31:16]};
		coef.t3 = {{16{temp_q[47]}}, temp_q[47:32]};
		coef.p1 = {16'd0, plow_q[15:0]};
		coef.p2 = {{16{plow_q[31]}}, plow_q[31:16]};
		coef.p3 = {{16{plow_q[47]}}, plow_q[47:32]};
		coef.p4 = {{16{plow_q[63]}}, plow_q[63:48]};
		coef.p5 = {{16{phigh_q[15]}}, phigh_q[15:0]};
		coef.p6 = {{16{phigh_q[31]}}, phigh_q[31:16]};
		coef.p7 = {{16{phigh_q[47]}}, phigh_q[47:32]};
		coef.p8 = {{16{phigh_q[63]}}, phigh_q[63:48]};
		coef.p9 = {{16{p9hum_q[15]}}, p9hum_q[15:0]};
		coef.h1 = {24'd0, p9hum_q[23:16]};
		coef.h2 = {{16{p9hum_q[39]}}, p9hum_q[39:24]};
		coef.h3 = {24'd0, p9hum_q[47:40]};
		coef.h4 = {{20{hum_q[11]}}, hum_q[11:0]};
		coef.h5 = {{20{hum_q[23]}}, hum_q[23:12]};
		coef.h6 = {{24{hum_q[31]}}, hum_q[31:24]};
	end

endmodule

@@ hdl/esc_front.sv @@
module esc_front (
	input  logic                 clk,
	input  logic                 en,
	input  esc_pkg::coef_t       coef,
	input  logic [19:0]          raw_pressure,
	input  logic [19:0]          raw_temperature,
	input  logic [15:0]          raw_humidity,
	output logic [31:0]          temp_s4,
	output logic [31:0]          hv_s4,
	output logic [15:0]          adch_s4,
	output logic [31:0]          dvd_s10,
	output logic [31:0]          dvs_s10,
	output logic                 mode_s10,
	output logic                 nz_s10
);

	logic [31:0] adc_t, x1, d;
	logic [31:0] m1_s1, dd_s1, ta_s2, m2_s2, fine_s3, pa_s4;
	logic [31:0] qq_s5, mp5_s5, mp2_s5, b1_s6, c1_s6, mp5_s6, mp2_s6;
	logic [31:0] pb_s7, a2_s7, m_s8, pb_s8, dvs_s9, n3_s9;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6, adcp_s7, adcp_s8;
	logic [15:0] adch_s1, adch_s2, adch_s3;
	logic [31:0] q4;

	assign adc_t = {12'd0, raw_temperature};
	assign x1    = (adc_t >> 3) - (coef.t1 << 1);
	assign d     = (adc_t >> 4) - coef.t1;
	assign q4    = esc_pkg::asr(pa_s4, 2);

	always_ff @(posedge clk) begin
		if (en) begin
			// temperature
			m1_s1   <= x1 * coef.t2;
			dd_s1   <= d * d;
			adcp_s1 <= raw_pressure;
			adch_s1 <= raw_humidity;
			ta_s2   <= esc_pkg::asr(m1_s1, 11);
			m2_s2   <= esc_pkg::asr(dd_s1, 12) * coef.t3;
			adcp_s2 <= adcp_s1;
			adch_s2 <= adch_s1;
			fine_s3 <= ta_s2 + esc_pkg::asr(m2_s2, 14);
			adcp_s3 <= adcp_s2;
			adch_s3 <= adch_s2;
			temp_s4 <= esc_pkg::asr((fine_s3 << 2) + fine_s3 + esc_pkg::K_ROUND128, 8);
			pa_s4   <= esc_pkg::asr(fine_s3, 1) - esc_pkg::K_64000;
			hv_s4   <= fine_s3 - esc_pkg::K_76800;
			adcp_s4 <= adcp_s3;
			adch_s4 <= adch_s3;
			// pressure divisor and dividend
			qq_s5   <= q4 * q4;
			mp5_s5  <= pa_s4 * coef.p5;
			mp2_s5  <= coef.p2 * pa_s4;
			adcp_s5 <= adcp_s4;
			b1_s6   <= esc_pkg::asr(qq_s5, 11) * coef.p6;
			c1_s6   <= coef.p3 * esc_pkg::asr(qq_s5, 13);
			mp5_s6  <= mp5_s5;
			mp2_s6  <= mp2_s5;
			adcp_s6 <= adcp_s5;
			pb_s7   <= esc_pkg::asr(b1_s6 + (mp5_s6 << 1), 2) + (coef.p4 << 16);
			a2_s7   <= esc_pkg::asr(esc_pkg::asr(c1_s6, 3) + esc_pkg::asr(mp2_s6, 1), 18);
			adcp_s7 <= adcp_s6;
			m_s8    <= (esc_pkg::K_32768 + a2_s7) * coef.p1;
			pb_s8   <= pb_s7;
			adcp_s8 <= adcp_s7;
			dvs_s9  <= esc_pkg::asr(m_s8, 15);
			n3_s9   <= ((esc_pkg::K_1048576 - {12'd0, adcp_s8}) - esc_pkg::asr(pb_s8, 12))
				* esc_pkg::K_3125;
			// large dividends are divided unshifted and doubled afterwards
			mode_s10 <= n3_s9[31];
			dvd_s10  <= n3_s9[31] ? n3_s9 : (n3_s9 << 1);
			dvs_s10  <= dvs_s9;
			nz_s10   <= (dvs_s9 != '0);
		end
	end

endmodule

@@ hdl/esc_hum.sv @@
module esc_hum (
	input  logic            clk,
	input  logic            en,
	input  esc_pkg::coef_t  coef,
	input  logic [31:0]     hv_s4,
	input  logic [15:0]     adch_s4,
	output logic [16:0]     hum_s12
);

	logic [31:0] mh5_s5, mv6_s5, mv3_s5, base_s5;
	logic [31:0] ha_s6, hb_s6, hc_s6, ha_s7, mbc_s7, ha_s8, mc2_s8;
	logic [31:0] v2_s9, v2_s10, mb_s10, v2_s11, r_s11;
	logic [31:0] b10, v3;
	logic [31:0] clamped;

	assign b10 = esc_pkg::asr(v2_s9, 15);
	assign v3  = v2_s11 - esc_pkg::asr(r_s11, 4);

	always_comb begin
		clamped = v3;
		if (v3[31])
			clamped = '0;
		else if (v3 > esc_pkg::K_HUM_MAX)
			clamped = esc_pkg::K_HUM_MAX;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mh5_s5  <= coef.h5 * hv_s4;
			mv6_s5  <= hv_s4 * coef.h6;
			mv3_s5  <= hv_s4 * coef.h3;
			base_s5 <= ({16'd0, adch_s4} << 14) - (coef.h4 << 20);
			ha_s6   <= esc_pkg::asr(base_s5 - mh5_s5 + esc_pkg::K_16384, 15);
			hb_s6   <= esc_pkg::asr(mv6_s5, 10);
			hc_s6   <= esc_pkg::asr(mv3_s5, 11) + esc_pkg::K_32768;
			ha_s7   <= ha_s6;
			mbc_s7  <= hb_s6 * hc_s6;
			ha_s8   <= ha_s7;
			mc2_s8  <= (esc_pkg::asr(mbc_s7, 10) + esc_pkg::K_2097152) * coef.h2;
			v2_s9   <= ha_s8 * esc_pkg::asr(mc2_s8 + esc_pkg::K_8192, 14);
			v2_s10  <= v2_s9;
			mb_s10  <= b10 * b10;
			v2_s11  <= v2_s10;
			r_s11   <= esc_pkg::asr(mb_s10, 7) * coef.h1;
			hum_s12 <= clamped[28:12];
		end
	end

endmodule

@@ hdl/esc_div.sv @@
module esc_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dvd,
	input  logic [31:0] dvs,
	input  logic        mode,
	input  logic        nz,
	output logic [31:0] quo,
	output logic        mode_out,
	output logic        nz_out
);

	localparam int unsigned N = esc_pkg::DivBits;

	// one quotient bit per stage, restoring
	logic [31:0] rem_s  [N];
	logic [31:0] dvd_s  [N];
	logic [31:0] dvs_s  [N];
	logic        mode_s [N];
	logic        nz_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [31:0] rem_in, dvd_in, dvs_in;
		logic        mode_in, nz_in;
		logic [32:0] sh, diff;
		logic        ge;
		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign dvd_in  = dvd;
			assign dvs_in  = dvs;
			assign mode_in = mode;
			assign nz_in   = nz;
		end else begin : g_rest
			assign rem_in  = rem_s[k-1];
			assign dvd_in  = dvd_s[k-1];
			assign dvs_in  = dvs_s[k-1];
			assign mode_in = mode_s[k-1];
			assign nz_in   = nz_s[k-1];
		end
		assign sh   = {rem_in, dvd_in[31]};
		assign diff = sh - {1'b0, dvs_in};
		assign ge   = (sh >= {1'b0, dvs_in});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[31:0] : sh[31:0];
				dvd_s[k]  <= {dvd_in[30:0], ge};
				dvs_s[k]  <= dvs_in;
				mode_s[k] <= mode_in;
				nz_s[k]   <= nz_in;
			end
		end
	end

	assign quo      = dvd_s[N-1];
	assign mode_out = mode_s[N-1];
	assign nz_out   = nz_s[N-1];

endmodule

@@ hdl/esc_ptrim.sv @@
module esc_ptrim (
	input  logic            clk,
	input  logic            en,
	input  esc_pkg::coef_t  coef,
	input  logic [31:0]     quo,
	input  logic            mode,
	input  logic            nz,
	output logic [31:0]     pres_out,
	output logic            pvalid_out
);

	logic [31:0] pres, x8, x4;
	logic [31:0] pres_s1, xx_s1, y_s1, pres_s2, pa_s2, pb_s2;
	logic        nz_s1, nz_s2;

	assign pres = mode ? (quo << 1) : quo;
	assign x8   = pres >> 3;
	assign x4   = pres >> 2;

	always_ff @(posedge clk) begin
		if (en) begin
			pres_s1    <= pres;
			xx_s1      <= x8 * x8;
			y_s1       <= x4 * coef.p8;
			nz_s1      <= nz;
			pres_s2    <= pres_s1;
			pa_s2      <= esc_pkg::asr(coef.p9 * (xx_s1 >> 13), 12);
			pb_s2      <= esc_pkg::asr(y_s1, 13);
			nz_s2      <= nz_s1;
			pres_out   <= nz_s2 ? pres_s2 + esc_pkg::asr(pa_s2 + pb_s2 + coef.p7, 4) : '0;
			pvalid_out <= nz_s2;
		end
	end

endmodule

@@ hdl/esc_checker.sv @@
module esc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] temperature_centi,
	input logic [31:0] pressure_pa,
	input logic        pressure_valid,
	input logic [16:0] humidity_q22_10
);

	// a held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pressure_pa)
			&& $stable(temperature_centi) && $stable(humidity_q22_10))
		else $error("held result beat changed");

	// input is stalled exactly when a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow the held output");

	// no pressure when the divisor was zero
	a_pzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_pa == 32'd0)
		else $error("pressure given with zero divisor");

	// humidity stays within 0..100 percent
	a_hrange: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q22_10 <= 17'd102400)
		else $error("humidity out of range");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.temperature_centi (temperature_centi),
	.pressure_pa       (pressure_pa),
	.pressure_valid    (pressure_valid),
	.humidity_q22_10   (humidity_q22_10)
);
